[rtl/static_arithmetic_encoder_assert.svh]
// Assertion macros for the arithmetic encoder.
`ifndef STATIC_ARITHMETIC_ENCODER_ASSERT_SVH
`define STATIC_ARITHMETIC_ENCODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SAE_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define SAE_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SAE_ASSERT_IMPL(label, clk, rstn, prop)
`define SAE_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

[rtl/sae_pkg.sv]
package sae_pkg;

    localparam int SYMBOLS = 256;
    localparam int SYM_W = 8;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [30:0] INTERVAL_TOP = 31'h7fffffff;
    localparam logic [30:0] HALF         = 31'h40000000;
    localparam logic [30:0] QUARTER1     = 31'h20000000;
    localparam logic [30:0] QUARTER3     = 31'h60000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  symbol;
        logic [30:0] count;
    } in_item_t;

    typedef struct packed {
        logic        lead_bit;
        logic [31:0] follow_count;
        logic        last;
    } out_item_t;

endpackage

[rtl/static_arithmetic_encoder.sv]
// Channel   | Dir | Handshake                  | Payload
// s_*       | in  | s_valid / s_ready          | s_data  (sae_pkg::in_item_t)
// m_*       | out | m_valid / m_ready          | m_data  (sae_pkg::out_item_t)
// cfg       | in  | cfg_we (no wait)           | cfg_wdata (total_count)
//
// Load: write back of both bounds. Encode: table read, restoring divider,
// quotient capture, two multiplies, one rescale step a cycle unless stalled at
// an emission, an end check, then release of the final emission and its drain.
// Flush: answered on acceptance. One transaction in flight at a time.
// Reset is synchronous, active low; the bound tables are not cleared.
// m_ready low stalls the rescale sequencer at an emission while one is held.
`include "static_arithmetic_encoder_assert.svh"
module static_arithmetic_encoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sae_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sae_pkg::out_item_t   m_data,
    input  logic                 cfg_we,
    input  logic [30:0]          cfg_wdata
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;  // table read in flight
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MULH = 3'd3;
    localparam logic [2:0] ST_MULL = 3'd4;
    localparam logic [2:0] ST_SCAL = 3'd5;
    localparam logic [2:0] ST_LOAD = 3'd6;
    localparam logic [2:0] ST_LAST = 3'd7;  // release held emission as last

    // Bound tables: one memory, both bounds per entry.
    logic [63:0] cum_mem [sae_pkg::SYMBOLS];
    logic [63:0] rd_reg;
    logic        mem_we;
    logic [sae_pkg::SYM_W-1:0] mem_addr;
    logic [63:0] mem_wdata;

    logic [2:0]  state_reg, state_next;
    sae_pkg::in_item_t item_reg, item_next;
    logic [30:0] total_reg, total_next;
    logic [31:0] sum_reg, sum_next;
    logic [30:0] low_reg, low_next;
    logic [30:0] high_reg, high_next;
    logic [31:0] pend_reg, pend_next;
    logic [31:0] step_reg, step_next;
    logic [31:0] prod_reg, prod_next;
    logic [4:0]  iter_reg, iter_next;
    logic        hold_vld_reg, hold_vld_next;
    sae_pkg::out_item_t hold_reg, hold_next;
    logic        m_valid_reg, m_valid_next;
    sae_pkg::out_item_t m_data_reg, m_data_next;

    logic        div_start, div_done;
    logic [31:0] div_q;
    logic [30:0] divisor;
    logic        out_free;
    logic        e1, e2, e3;
    logic [30:0] lo_s, hi_s;

    sae_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({1'b0, high_reg - low_reg} + 32'd1),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign divisor  = (total_reg == '0) ? 31'd1 : total_reg;
    assign s_ready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign e1 = high_reg < sae_pkg::HALF;
    assign e2 = low_reg >= sae_pkg::HALF;
    assign e3 = (low_reg >= sae_pkg::QUARTER1) && (high_reg < sae_pkg::QUARTER3);

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        total_next    = cfg_we ? cfg_wdata : total_reg;
        sum_next      = sum_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        pend_next     = pend_reg;
        step_next     = step_reg;
        prod_next     = prod_reg;
        iter_next     = iter_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = item_reg.symbol;
        mem_wdata     = '0;
        lo_s          = low_reg;
        hi_s          = high_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    mem_addr  = s_data.symbol;
                    case (s_data.op)
                        sae_pkg::OP_LOAD:   state_next = ST_LOAD;
                        sae_pkg::OP_ENCODE: state_next = ST_READ;
                        sae_pkg::OP_FLUSH: begin
                            m_valid_next = 1'b1;
                            m_data_next.lead_bit = (low_reg >= sae_pkg::QUARTER1);
                            m_data_next.follow_count =
                                (pend_reg == '1) ? pend_reg : pend_reg + 32'd1;
                            m_data_next.last = 1'b1;
                            low_next  = '0;
                            high_next = sae_pkg::INTERVAL_TOP;
                            pend_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                mem_we    = 1'b1;
                sum_next  = sum_reg + {1'b0, item_reg.count};
                mem_wdata = {sum_next, sum_reg};
                state_next = ST_IDLE;
            end
            ST_READ: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    step_next  = div_q;
                    state_next = ST_MULH;
                end
            end
            ST_MULH: begin
                prod_next  = 32'(step_reg * rd_reg[63:32]);
                state_next = ST_MULL;
            end
            ST_MULL: begin
                high_next     = 31'({1'b0, low_reg} + prod_reg - 32'd1);
                low_next      = 31'({1'b0, low_reg} + 32'(step_reg * rd_reg[31:0]));
                iter_next     = '0;
                hold_vld_next = 1'b0;
                state_next    = ST_SCAL;
            end
            ST_SCAL: begin
                // Each emission is held until the next one so the final one can carry last.
                if (!(e1 || e2 || e3)) begin
                    state_next = ST_LAST;
                end else if (!(e1 || e2) || !hold_vld_reg || out_free) begin
                    if (e1 || e2) begin
                        if (hold_vld_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = hold_reg;
                        end
                        hold_next.lead_bit     = !e1;
                        hold_next.follow_count = pend_reg;
                        hold_next.last         = 1'b0;
                        hold_vld_next = 1'b1;
                        pend_next = '0;
                        if (!e1) begin
                            lo_s = low_reg - sae_pkg::HALF;
                            hi_s = high_reg - sae_pkg::HALF;
                        end
                    end else begin
                        if (pend_reg != '1) pend_next = pend_reg + 32'd1;
                        lo_s = low_reg - sae_pkg::QUARTER1;
                        hi_s = high_reg - sae_pkg::QUARTER1;
                    end
                    low_next  = {lo_s[29:0], 1'b0};
                    high_next = {hi_s[29:0], 1'b1};
                    iter_next = iter_reg + 5'd1;
                    if (iter_reg == 5'd30) state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (!hold_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = hold_reg;
                    m_data_next.last = 1'b1;
                    hold_vld_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Bound table: written on load, registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) cum_mem[mem_addr] <= mem_wdata;
        rd_reg <= cum_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        step_reg    <= step_next;
        prod_reg    <= prod_next;
        iter_reg    <= iter_next;
        hold_reg    <= hold_next;
        m_data_reg  <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= 31'd1;
            sum_reg      <= '0;
            low_reg      <= '0;
            high_reg     <= sae_pkg::INTERVAL_TOP;
            pend_reg     <= '0;
            hold_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            sum_reg      <= sum_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            pend_reg     <= pend_next;
            hold_vld_reg <= hold_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SAE_ASSERT_IMPL(a_busy_no_ready, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_ready)
    `SAE_ASSERT_NEXT(a_div_follows, aclk, aresetn, state_reg == ST_READ, state_reg == ST_DIV)
    `SAE_ASSERT_NEXT(a_flush_emits, aclk, aresetn, s_valid && s_ready && s_data.op == sae_pkg::OP_FLUSH, m_valid && m_data.last)
    `SAE_ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
endmodule

[rtl/sae_divider.sv]
// Restoring divider, one quotient bit per cycle.
module sae_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {2'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    // Allow margin for encoder wind-down when draining.
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    sae_pkg::in_item_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    sae_pkg::out_item_t m_data;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    static_arithmetic_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------
    // Coder state mirror
    // ---------------------------------------------------------------
    logic [31:0] sym_lo_bound [sae_pkg::SYMBOLS];
    logic [31:0] sym_hi_bound [sae_pkg::SYMBOLS];
    bit          sym_loaded   [sae_pkg::SYMBOLS];
    logic [31:0] freq_sum;
    logic [30:0] iv_low;
    logic [30:0] iv_high;
    logic [31:0] underflow_cnt;
    logic [30:0] divisor_reg;

    sae_pkg::out_item_t emit_queue [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          sink_wait = 0;
    bit          hold_sink = 1'b0;

    function automatic void coder_restart();
        iv_low        = '0;
        iv_high       = sae_pkg::INTERVAL_TOP;
        underflow_cnt = '0;
    endfunction

    // Compute the emissions caused by one transaction and queue them.
    task automatic predict_emissions(input sae_pkg::in_item_t it);
        logic [63:0] lo, hi, span, stp, dv;
        sae_pkg::out_item_t r;
        int          n;
        n = 0;
        case (it.op)
            sae_pkg::OP_LOAD: begin
                sym_lo_bound[it.symbol] = freq_sum;
                freq_sum = freq_sum + {1'b0, it.count};
                sym_hi_bound[it.symbol] = freq_sum;
                sym_loaded[it.symbol] = 1'b1;
            end
            sae_pkg::OP_ENCODE: begin
                dv   = (divisor_reg == 0) ? 64'd1 : {33'd0, divisor_reg};
                lo   = {33'd0, iv_low};
                hi   = {33'd0, iv_high};
                span = ((hi - lo) & 64'h7fffffff) + 64'd1;
                stp  = span / dv;
                hi   = (lo + stp * {32'd0, sym_hi_bound[it.symbol]} - 64'd1) & 64'h7fffffff;
                lo   = (lo + stp * {32'd0, sym_lo_bound[it.symbol]}) & 64'h7fffffff;
                for (int i = 0; i < 31; i++) begin
                    if (hi < sae_pkg::HALF) begin
                        r = '{lead_bit: 1'b0, follow_count: underflow_cnt, last: 1'b0};
                        emit_queue.push_back(r);
                        n++;
                        underflow_cnt = '0;
                    end else if (lo >= sae_pkg::HALF) begin
                        r = '{lead_bit: 1'b1, follow_count: underflow_cnt, last: 1'b0};
                        emit_queue.push_back(r);
                        n++;
                        underflow_cnt = '0;
                        lo -= sae_pkg::HALF;
                        hi -= sae_pkg::HALF;
                    end else if (lo >= sae_pkg::QUARTER1 && hi < sae_pkg::QUARTER3) begin
                        if (underflow_cnt != 32'hffffffff) underflow_cnt++;
                        lo -= sae_pkg::QUARTER1;
                        hi -= sae_pkg::QUARTER1;
                    end else begin
                        break;
                    end
                    lo = (lo << 1) & 64'h7fffffff;
                    hi = ((hi << 1) | 64'd1) & 64'h7fffffff;
                end
                iv_low  = lo[30:0];
                iv_high = hi[30:0];
                if (n > 0) emit_queue[emit_queue.size() - 1].last = 1'b1;
            end
            sae_pkg::OP_FLUSH: begin
                r.lead_bit     = (iv_low < sae_pkg::QUARTER1) ? 1'b0 : 1'b1;
                r.follow_count = (underflow_cnt == 32'hffffffff) ? underflow_cnt
                                                                 : underflow_cnt + 32'd1;
                r.last         = 1'b1;
                emit_queue.push_back(r);
                coder_restart();
            end
            default: ;  // spare op code: no emission
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // Valid stays up after a transaction; a send with a gap or wait_drained drops it.
    task automatic send_item(input sae_pkg::in_item_t it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_emissions(it);
    endtask

    task automatic load_item(input logic [7:0] sym, input logic [30:0] cnt);
        sae_pkg::in_item_t it;
        it = '{op: sae_pkg::OP_LOAD, symbol: sym, count: cnt};
        send_item(it);
    endtask

    task automatic encode_item(input logic [7:0] sym);
        sae_pkg::in_item_t it;
        it = '{op: sae_pkg::OP_ENCODE, symbol: sym, count: 31'($urandom)};
        send_item(it);
    endtask

    task automatic flush_item();
        sae_pkg::in_item_t it;
        it = '{op: sae_pkg::OP_FLUSH, symbol: 8'($urandom), count: 31'($urandom)};
        send_item(it);
    endtask

    // Wait for every expected emission plus encoder wind-down.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (emit_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_total(input logic [30:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        divisor_reg = v;
    endtask

    // Pad the running sum back to zero so fresh bounds start at zero.
    task automatic align_sum();
        logic [31:0] need;
        logic [30:0] part;
        need = 32'd0 - freq_sum;
        while (need != 0) begin
            part = (need > 32'h7fffffff) ? 31'h7fffffff : need[30:0];
            load_item(8'd200, part);
            need = 32'd0 - freq_sum;
        end
    endtask

    // Load a fresh frequency table; counts sum to the returned total.
    task automatic load_table(input int nsym, input int maxc, output logic [30:0] tot);
        logic [30:0] c;
        tot = 0;
        for (int s = 0; s < nsym; s++) begin
            c = 31'($urandom_range(1, maxc));
            load_item(8'(s), c);
            tot += c;
        end
    endtask

    function automatic logic [7:0] pick_loaded(input int nsym);
        return 8'($urandom_range(0, nsym - 1));
    endfunction

    // ---------------------------------------------------------------
    // Result sink: random wait states after each transaction, plus a long hold-off
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || hold_sink) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            sink_wait = $urandom_range(0, 3);
            m_ready <= (sink_wait == 0);
        end else if (sink_wait != 0) begin
            sink_wait = sink_wait - 1;
            m_ready <= (sink_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (emit_queue.size() == 0) begin
                report_mismatch("unexpected transaction", 32'(m_data.lead_bit), 32'd0);
            end else begin
                sae_pkg::out_item_t e;
                e = emit_queue.pop_front();
                if (m_data.lead_bit !== e.lead_bit)
                    report_mismatch("lead_bit", 32'(m_data.lead_bit), 32'(e.lead_bit));
                if (m_data.follow_count !== e.follow_count)
                    report_mismatch("follow_count", m_data.follow_count, e.follow_count);
                if (m_data.last !== e.last)
                    report_mismatch("last", 32'(m_data.last), 32'(e.last));
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    logic [30:0] table_total;

    // Extremes: max count, zero count, spare op, total_count zero.
    task automatic test_directed();
        sae_pkg::in_item_t it;
        load_item(8'd0, 31'd1);
        load_item(8'd255, 31'd1);
        load_item(8'd1, 31'd0);             // empty range symbol
        load_item(8'd2, 31'h40000000);      // largest legal count
        load_item(8'd3, 31'h7fffffff);      // all ones, largest 31-bit count
        it = '{op: 2'd3, symbol: 8'hff, count: 31'h7fffffff};
        send_item(it);                      // spare op code, ignored
        encode_item(8'd0);
        encode_item(8'd255);
        encode_item(8'd1);
        encode_item(8'd2);
        encode_item(8'd3);
        flush_item();
        flush_item();
        write_total(31'd0);                 // zero divisor acts as one
        encode_item(8'd0);
        encode_item(8'd255);
        flush_item();
        write_total(31'h7fffffff);
        encode_item(8'd3);
        encode_item(8'd2);
        flush_item();
    endtask

    // Well-formed message: table whose counts sum to total_count, then symbols.
    task automatic test_messages(input int nmsg);
        int nsym, len;
        for (int m = 0; m < nmsg; m++) begin
            nsym = $urandom_range(2, 8);
            wait_drained();
            align_sum();
            load_table(nsym, (m % 3 == 0) ? 1 : 1000, table_total);
            write_total(table_total);
            len = $urandom_range(4, 20);
            for (int k = 0; k < len; k++) encode_item(pick_loaded(nsym));
            flush_item();
        end
    endtask

    // Skewed table: one dominant symbol drives long underflow runs.
    task automatic test_underflow();
        wait_drained();
        align_sum();
        load_item(8'd10, 31'd1);
        load_item(8'd11, 31'h3fffffff);
        load_item(8'd12, 31'd1);
        write_total(31'h40000001);
        for (int k = 0; k < 20; k++) encode_item(8'(($urandom_range(0, 3) == 0) ? 10 : 11));
        flush_item();
    endtask

    // Receiver holds off while sender keeps offering; then sender waits.
    task automatic test_backpressure();
        hold_sink = 1'b1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_sink = 1'b0;
            end
            begin
                for (int k = 0; k < 12; k++) encode_item(8'(k % 4));
                flush_item();
            end
        join
        wait_drained();
    endtask

    // Noise: random ops with random content, including bad op and random symbols.
    task automatic test_noise(input int n);
        sae_pkg::in_item_t it;
        for (int k = 0; k < n; k++) begin
            it.op     = 2'($urandom_range(0, 3));
            it.symbol = 8'($urandom);
            it.count  = ($urandom_range(0, 1)) ? 31'($urandom) : 31'($urandom_range(0, 50));
            // Encoding an untouched entry is not allowed.
            if (it.op == sae_pkg::OP_ENCODE && !sym_loaded[it.symbol])
                it.op = sae_pkg::OP_FLUSH;
            send_item(it);
        end
        flush_item();
    endtask

    initial begin
        freq_sum    = '0;
        divisor_reg = 31'd1;
        coder_restart();
        for (int s = 0; s < sae_pkg::SYMBOLS; s++) sym_loaded[s] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_messages(12);
        test_underflow();
        test_backpressure();
        write_total(31'd7);
        test_noise(60);
        test_messages(5);

        wait_drained();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
